/* sv/uvs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared types and constants for the unique value stack: field widths,
// result status codes and the controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package uvs_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int FUNC_W        = 1;
   localparam int DIN_W         = 32;
   localparam int DATA_W        = 31;
   localparam int STATUS_W      = 3;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 3'd0,
      ST_NEG   = 3'd1,
      ST_DUP   = 3'd2,
      ST_FULL  = 3'd3,
      ST_EMPTY = 3'd4
   } status_type;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH = 1'b0,
      FUNC_POP  = 1'b1
   } func_type;

   // source of the result value
   typedef enum logic [1:0] {
      SEL_ZERO  = 2'd0,
      SEL_VALUE = 2'd1,
      SEL_READ  = 2'd2
   } rsp_sel_type;

   typedef struct packed {
      logic        load_req;
      logic        scan_clear;
      logic        rd_scan;
      logic        rd_top;
      logic        wr_push;
      logic        dec_count;
      logic        load_rsp;
      status_type  rsp_status;
      rsp_sel_type rsp_sel;
   } uvs_cmd_type;

   typedef struct packed {
      logic is_pop;
      logic negative;
      logic empty;
      logic full;
      logic scan_last;
      logic dup;
      logic out_free;
   } uvs_stat_type;

endpackage : uvs_pkg
`default_nettype wire

/* sv/uvs_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uvs_req_if / uvs_rsp_if
// Valid/ready channels for stack requests and results.
// ----------------------------------------------------------------------------
interface uvs_req_if;
   import uvs_pkg::*;
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [DIN_W-1:0]  data_in;

   modport source (output valid, input ready, output func, output data_in);
   modport sink   (input valid, output ready, input func, input data_in);
endinterface : uvs_req_if

interface uvs_rsp_if;
   import uvs_pkg::*;
   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   data_out;
   logic [STATUS_W-1:0] status;

   modport source (output valid, input ready, output data_out, output status);
   modport sink   (input valid, output ready, input data_out, input status);
endinterface : uvs_rsp_if
`default_nettype wire

/* sv/uvs_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uvs_ctrl
// Sequencer for the unique value stack: accepts one item, runs the duplicate
// scan or the top read, and issues the result load.
// ----------------------------------------------------------------------------
module uvs_ctrl
   import uvs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire uvs_stat_type stat,
   output uvs_cmd_type       cmd
);

   typedef enum logic [4:0] {
      S_IDLE     = 5'b00001,
      S_DECIDE   = 5'b00010,
      S_SCAN     = 5'b00100,
      S_DRAIN    = 5'b01000,
      S_POP_WAIT = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.rsp_status = ST_OK;
      cmd.rsp_sel    = SEL_ZERO;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECIDE;
            end
         end
         S_DECIDE: begin
            priority if (stat.is_pop) begin
               if (stat.empty) begin
                  if (stat.out_free) begin
                     cmd.load_rsp   = 1'b1;
                     cmd.rsp_status = ST_EMPTY;
                     state_in       = S_IDLE;
                  end
               end else begin
                  cmd.rd_top = 1'b1;
                  state_in   = S_POP_WAIT;
               end
            end else if (stat.negative) begin
               if (stat.out_free) begin
                  cmd.load_rsp   = 1'b1;
                  cmd.rsp_status = ST_NEG;
                  state_in       = S_IDLE;
               end
            end else if (stat.empty) begin
               if (stat.out_free) begin
                  cmd.wr_push  = 1'b1;
                  cmd.load_rsp = 1'b1;
                  cmd.rsp_sel  = SEL_VALUE;
                  state_in     = S_IDLE;
               end
            end else begin
               cmd.scan_clear = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.rd_scan = 1'b1;
            if (stat.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (stat.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
               priority if (stat.dup) begin
                  cmd.rsp_status = ST_DUP;
               end else if (stat.full) begin
                  cmd.rsp_status = ST_FULL;
               end else begin
                  cmd.wr_push = 1'b1;
                  cmd.rsp_sel = SEL_VALUE;
               end
            end
         end
         S_POP_WAIT: begin
            if (stat.out_free) begin
               cmd.dec_count = 1'b1;
               cmd.load_rsp  = 1'b1;
               cmd.rsp_sel   = SEL_READ;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule : uvs_ctrl
`default_nettype wire

/* sv/uvs_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uvs_dp
// Datapath for the unique value stack: entry memory with one registered read
// port, entry count, scan pointer, duplicate flag and result register.
// ----------------------------------------------------------------------------
module uvs_dp
   import uvs_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [FUNC_W-1:0]   req_func,
   input  wire logic [DIN_W-1:0]    req_data_in,
   input  wire logic                rsp_ready,
   output logic                     rsp_valid,
   output logic [DATA_W-1:0]        rsp_data_out,
   output logic [STATUS_W-1:0]      rsp_status,
   input  wire uvs_cmd_type         cmd,
   output uvs_stat_type             stat
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [DATA_W-1:0] mem [DEPTH];

   logic [FUNC_W-1:0]   func_ff;
   logic                neg_ff;
   logic [DATA_W-1:0]   value_ff;
   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;
   logic [CW-1:0]       scan_ptr_ff;
   logic [CW-1:0]       scan_ptr_in;
   logic                rd_vld_ff;
   logic                rd_vld_in;
   logic [DATA_W-1:0]   rd_data_ff;
   logic                dup_ff;
   logic                dup_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [DATA_W-1:0]   data_out_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [CW-1:0]       top_idx;
   logic                hit;

   assign top_idx = count_ff - CW'(1);
   assign hit     = rd_vld_ff && (rd_data_ff == value_ff);

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff  <= req_func;
         neg_ff   <= req_data_in[DIN_W-1];
         value_ff <= req_data_in[DATA_W-1:0];
      end
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (cmd.wr_push) begin
         mem[count_ff[AW-1:0]] <= value_ff;
      end
      if (cmd.rd_scan) begin
         rd_data_ff <= mem[scan_ptr_ff[AW-1:0]];
      end else if (cmd.rd_top) begin
         rd_data_ff <= mem[top_idx[AW-1:0]];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.wr_push) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.dec_count) begin
         count_in = top_idx;
      end
      scan_ptr_in = cmd.scan_clear ? '0 :
                    (cmd.rd_scan ? scan_ptr_ff + CW'(1) : scan_ptr_ff);
      rd_vld_in   = cmd.rd_scan;
      dup_in      = cmd.scan_clear ? 1'b0 : (dup_ff | hit);
      rsp_valid_in = cmd.load_rsp ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         scan_ptr_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         dup_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         scan_ptr_ff  <= scan_ptr_in;
         rd_vld_ff    <= rd_vld_in;
         dup_ff       <= dup_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         status_ff <= cmd.rsp_status;
         unique case (cmd.rsp_sel)
            SEL_VALUE: data_out_ff <= value_ff;
            SEL_READ:  data_out_ff <= rd_data_ff;
            default:   data_out_ff <= '0;
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = data_out_ff;
   assign rsp_status   = status_ff;

   assign stat.is_pop    = (func_ff == FUNC_POP);
   assign stat.negative  = neg_ff;
   assign stat.empty     = (count_ff == '0);
   assign stat.full      = (count_ff == CW'(DEPTH));
   assign stat.scan_last = (scan_ptr_ff == top_idx);
   assign stat.dup       = dup_ff | hit;
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

endmodule : uvs_dp
`default_nettype wire

/* sv/unique_value_stack_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// unique_value_stack_core
// Bounded LIFO stack of non-negative 31-bit values that rejects duplicates.
// ----------------------------------------------------------------------------
// Each request item yields exactly one result item. A push is checked in the
// order negative, duplicate, full; only an accepted push changes the stack and
// echoes its value, every failure returns zero data with a nonzero status.
// One item is handled at a time. A push of a non-negative value onto a
// non-empty stack runs a duplicate check before the result register is
// loaded; the check reads the entries one per cycle through the single read
// port of the entry memory. A negative value or an empty stack skips it.
// A pop reads the top entry into the read register before the result is
// loaded; a pop on an empty stack loads its result directly. The next item
// can be accepted in the cycle after the result load. A new item is accepted
// while the previous result still waits in the output register; its final
// step then waits until that result is taken.
module unique_value_stack_core
   import uvs_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   uvs_req_if.sink   req_ch,
   uvs_rsp_if.source rsp_ch
);

   uvs_cmd_type  cmd;
   uvs_stat_type stat;

   uvs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   uvs_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_func     (req_ch.func),
      .req_data_in  (req_ch.data_in),
      .rsp_ready    (rsp_ch.ready),
      .rsp_valid    (rsp_ch.valid),
      .rsp_data_out (rsp_ch.data_out),
      .rsp_status   (rsp_ch.status),
      .cmd          (cmd),
      .stat         (stat)
   );

endmodule : unique_value_stack_core
`default_nettype wire

/* sv/uvs_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uvs_checker
// Port-level checks for the unique value stack, bound to the top level.
// ----------------------------------------------------------------------------
module uvs_checker
   import uvs_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [DATA_W-1:0]   rsp_data_out,
   input wire logic [STATUS_W-1:0] rsp_status
);

   // no result right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_out) && $stable(rsp_status))
      else $error("stalled result changed");

   // failures carry zero data
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_data_out == '0)
      else $error("failed item with nonzero data");

   // status code in range
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK) || (rsp_status == ST_NEG) ||
                    (rsp_status == ST_DUP) || (rsp_status == ST_FULL) ||
                    (rsp_status == ST_EMPTY))
      else $error("undefined status code");

   // busy after taking an item
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while busy");

endmodule : uvs_checker

bind unique_value_stack_core uvs_checker u_uvs_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_data_out (rsp_ch.data_out),
   .rsp_status   (rsp_ch.status)
);
`default_nettype wire

/* sim/unique_value_stack_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_value_stack_core_test
// Self-checking bench for the duplicate-rejecting stack. Requests go in on the
// req channel and a shadow copy of the stack predicts each result. The checker
// compares every result item against the oldest prediction. Stimulus is a
// short directed run of the corner cases, then fill/drain sequences and random
// walks under three idling mixes, plus a long result back-pressure stretch.
// ----------------------------------------------------------------------------
module unique_value_stack_core_test;
   import uvs_pkg::*;

   localparam int STACK_DEPTH = DEPTH_DEFAULT;
   localparam int IDLE_LIMIT  = 4000;
   localparam int HOLD_CYCLES = 300;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      status_type        status;
   } stack_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   uvs_req_if req_if ();
   uvs_rsp_if rsp_if ();

   unique_value_stack_core #(.DEPTH(STACK_DEPTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // shadow copy of the stack
   logic [DATA_W-1:0] shadow_stack [STACK_DEPTH];
   int                shadow_count = 0;
   stack_result_type  pending_results [$];

   int send_idle_pct  = 0;
   int rsp_idle_pct   = 0;
   int rsp_hold_left  = 0;
   int hold_requests  = 0;
   int holds_started  = 0;
   int error_count    = 0;
   int items_sent     = 0;
   int results_seen   = 0;
   int stall_cycles   = 0;
   int status_hits [5] = '{default: 0};

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic stack_result_type predict_stack_result(func_type f,
                                                             logic [DIN_W-1:0] d);
      stack_result_type  r;
      logic [DATA_W-1:0] v;
      bit                seen;
      r.data = '0;
      r.status = ST_OK;
      v = d[DATA_W-1:0];
      seen = 1'b0;
      if (f == FUNC_PUSH) begin
         for (int k = 0; k < shadow_count; k++)
            if (shadow_stack[k] == v) seen = 1'b1;
         if (d[DIN_W-1]) begin
            r.status = ST_NEG;
         end else if (seen) begin
            r.status = ST_DUP;
         end else if (shadow_count >= STACK_DEPTH) begin
            r.status = ST_FULL;
         end else begin
            shadow_stack[shadow_count] = v;
            shadow_count++;
            r.data = v;
         end
      end else if (shadow_count == 0) begin
         r.status = ST_EMPTY;
      end else begin
         shadow_count--;
         r.data = shadow_stack[shadow_count];
      end
      return r;
   endfunction

   // mix of fresh, stored, small and negative values
   function automatic logic [DIN_W-1:0] pick_push_data();
      int sel;
      sel = $urandom_range(99);
      if (sel < 15) return {1'b1, 31'($urandom)};
      if (sel < 40 && shadow_count > 0)
         return {1'b0, shadow_stack[$urandom_range(shadow_count - 1)]};
      if (sel < 60) return DIN_W'($urandom_range(31));
      if (sel < 63) return 32'h7fff_ffff;
      return {1'b0, 31'($urandom)};
   endfunction

   task automatic send_request(func_type f, logic [DIN_W-1:0] d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.func    <= f;
      req_if.data_in <= d;
      do @(posedge clock); while (!req_if.ready);
      pending_results.push_back(predict_stack_result(f, d));
      items_sent++;
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // result side: random stalls or a counted hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_requests != holds_started) begin
         rsp_if.ready  <= 1'b0;
         holds_started <= hold_requests;
         rsp_hold_left <= HOLD_CYCLES;
      end else if (rsp_hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_hold_left <= rsp_hold_left - 1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      stack_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("ERROR: result with nothing pending: data_out=%h status=%0d",
                        rsp_if.data_out, rsp_if.status);
         end else begin
            want = pending_results.pop_front();
            results_seen++;
            status_hits[want.status]++;
            if (rsp_if.data_out !== want.data || rsp_if.status !== want.status) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display({"ERROR: result %0d: expected data_out=%h status=%0d, ",
                            "got data_out=%h status=%0d"},
                           results_seen, want.data, want.status,
                           rsp_if.data_out, rsp_if.status);
            end
         end
      end
   end

   // ends the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= IDLE_LIMIT) begin
         $display("ERROR: no item moved for %0d cycles", IDLE_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic test_directed();
      send_request(FUNC_POP, 32'hffff_ffff);
      send_request(FUNC_PUSH, 32'h0000_0000);
      send_request(FUNC_PUSH, 32'h0000_0000);
      send_request(FUNC_PUSH, 32'h7fff_ffff);
      send_request(FUNC_PUSH, 32'h8000_0000);
      send_request(FUNC_PUSH, 32'hffff_ffff);
      send_request(FUNC_PUSH, 32'h7fff_ffff);
      send_request(FUNC_PUSH, 32'h5555_5555);
      send_request(FUNC_PUSH, 32'h2aaa_aaaa);
      send_request(FUNC_POP, 32'h0000_0000);
      send_request(FUNC_POP, 32'h8000_0000);
      send_request(FUNC_POP, 32'h1234_5678);
      send_request(FUNC_POP, 32'h0000_0000);
      send_request(FUNC_POP, 32'h0000_0000);
      send_request(FUNC_PUSH, 32'h0000_0001);
      send_request(FUNC_POP, 32'h0000_0000);
      send_request(FUNC_POP, 32'h0000_0000);
      wait_drained();
   endtask

   // fill to the top, knock on a full stack, drain past empty
   task automatic run_fill_drain();
      int tries;
      tries = 0;
      while (shadow_count < STACK_DEPTH && tries < 4 * STACK_DEPTH) begin
         send_request(FUNC_PUSH, {1'b0, 31'($urandom)});
         tries++;
      end
      send_request(FUNC_PUSH, {1'b0, 31'($urandom)});
      if (shadow_count > 0)
         send_request(FUNC_PUSH, {1'b0, shadow_stack[$urandom_range(shadow_count - 1)]});
      send_request(FUNC_PUSH, {1'b1, 31'($urandom)});
      while (shadow_count > 0) send_request(FUNC_POP, DIN_W'($urandom));
      send_request(FUNC_POP, DIN_W'($urandom));
   endtask

   task automatic run_random_walk(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 55) send_request(FUNC_PUSH, pick_push_data());
         else send_request(FUNC_POP, DIN_W'($urandom));
      end
   endtask

   task automatic test_random_traffic(int send_pct, int rsp_pct, int n);
      int start;
      start = items_sent;
      send_idle_pct = send_pct;
      rsp_idle_pct = rsp_pct;
      while (items_sent - start < n) begin
         if ($urandom_range(99) < 40) run_fill_drain();
         else run_random_walk($urandom_range(10, 40));
      end
      wait_drained();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_requests++;
      for (int i = 0; i < 12; i++) send_request(FUNC_PUSH, pick_push_data());
      for (int i = 0; i < 6; i++) send_request(FUNC_POP, DIN_W'($urandom));
      wait_drained();
   endtask

   initial begin
      req_if.valid   <= 1'b0;
      req_if.func    <= FUNC_PUSH;
      req_if.data_in <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_traffic(15, 85, 270);
      test_random_traffic(85, 15, 270);
      test_random_traffic(0, 0, 270);
      test_backpressure();
      repeat (40) @(posedge clock);
      $display("covered %0d requests and %0d results over three idling mixes and a held output",
               items_sent, results_seen);
      $display("statuses seen: %0d ok, %0d negative, %0d duplicate, %0d full, %0d empty",
               status_hits[ST_OK], status_hits[ST_NEG], status_hits[ST_DUP],
               status_hits[ST_FULL], status_hits[ST_EMPTY]);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches, %0d results never arrived", error_count,
                  pending_results.size());
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule : unique_value_stack_core_test

/* unique_value_stack_core.f */
sv/uvs_pkg.sv
sv/uvs_if.sv
sv/uvs_ctrl.sv
sv/uvs_dp.sv
sv/unique_value_stack_core.sv
sv/uvs_checker.sv
sim/unique_value_stack_core_test.sv
